FILE: src/csc_pkg.sv
// ============================================================================
// csc_pkg
// Shared types, codes and constants of the charge socket controller.
// ============================================================================
package csc_pkg;

    // Number of sockets served by the block (1 to 4).
    localparam int SOCKETS      = 2;
    localparam int SOCK_IDX_W   = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    // Milliseconds in one minute.
    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

    // Configuration register reset values.
    localparam logic [15:0] RST_CHECK_INTERVAL = 16'd500;
    localparam logic [31:0] RST_NC_DELAY       = 32'd10000;
    localparam logic [31:0] RST_NC_WINDOW      = 32'd15000;
    localparam logic [31:0] RST_PULSE_MIN      = 32'd5000;
    localparam logic [15:0] RST_DEFAULT_MIN    = 16'd60;

    typedef enum logic [1:0] {
        OP_CHECK   = 2'd0,
        OP_START   = 2'd1,
        OP_STOP    = 2'd2,
        OP_UNKNOWN = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        OUT_NONE      = 3'd0,
        OUT_STARTED   = 3'd1,
        OUT_START_IGN = 3'd2,
        OUT_STOPPED   = 3'd3,
        OUT_STOP_IGN  = 3'd4,
        OUT_ENDED     = 3'd5,
        OUT_BAD       = 3'd6
    } t_outcome;

    typedef enum logic [1:0] {
        END_TIME_UP    = 2'd0,
        END_MANUAL     = 2'd1,
        END_FUSE       = 2'd2,
        END_NO_CURRENT = 2'd3
    } t_end;

    typedef enum logic [2:0] {
        CFG_CHECK_INTERVAL = 3'd0,
        CFG_NC_DELAY       = 3'd1,
        CFG_NC_WINDOW      = 3'd2,
        CFG_PULSE_MIN      = 3'd3,
        CFG_DEFAULT_MIN    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] check_interval_ms;
        logic [31:0] no_current_delay_ms;
        logic [31:0] no_current_window_ms;
        logic [31:0] pulse_check_min_ms;
        logic [15:0] default_minutes;
    } t_cfg;

    // A classified item as it travels from the front part to the back part.
    typedef struct packed {
        t_op                   op;
        logic                  bad;
        logic [1:0]            socket;
        logic [SOCK_IDX_W-1:0] idx;
        logic [31:0]           now_ms;
        logic [31:0]           pulse_count;
        logic                  fuse_blown;
        logic [31:0]           limit_ms;
        logic [31:0]           order_tag;
    } t_item;

    // State kept for one socket.
    typedef struct packed {
        logic        charging;
        logic [31:0] start_time;
        logic [31:0] limit_ms;
        logic [31:0] last_pulse_count;
        logic [31:0] last_pulse_time;
        logic [31:0] last_check_time;
        logic [31:0] held_order_tag;
        t_end        last_end_reason;
    } t_sock;

    typedef struct packed {
        logic [1:0]  socket;
        t_outcome    outcome;
        logic        relay_closed;
        logic        finished_event;
        t_end        stop_cause;
        logic [31:0] finished_tag;
    } t_result;

endpackage

FILE: src/csc_front.sv
// ============================================================================
// csc_front
// Takes input beats, classifies them and works out the charge time limit.
// ============================================================================
module csc_front import csc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [1:0]  i_socket,
    input  logic [31:0] i_now_ms,
    input  logic [31:0] i_pulse_count,
    input  logic        i_fuse_blown,
    input  logic [15:0] i_minutes,
    input  logic [31:0] i_order_tag,
    input  logic [15:0] i_default_minutes,
    input  logic        i_queue_full,
    output logic        o_push,
    output t_item       o_item
);

    logic        r_valid;
    t_item       r_item;
    t_item       n_item;
    logic        load;
    logic        bad;
    logic [15:0] dur_min;

    assign o_in_stall = r_valid && i_queue_full;
    assign load       = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_queue_full;
    assign o_item     = r_item;

    always_comb begin
        bad     = ({1'b0, i_socket} >= 3'(SOCKETS));
        dur_min = (i_minutes != 16'd0) ? i_minutes : i_default_minutes;

        n_item             = '0;
        n_item.op          = t_op'(i_opcode);
        n_item.bad         = bad;
        n_item.socket      = i_socket;
        // A rejected socket never touches state, so it indexes entry zero.
        n_item.idx         = bad ? '0 : i_socket[SOCK_IDX_W-1:0];
        n_item.now_ms      = i_now_ms;
        n_item.pulse_count = i_pulse_count;
        n_item.fuse_blown  = i_fuse_blown;
        n_item.limit_ms    = {16'd0, dur_min} * {16'd0, MS_PER_MINUTE};
        n_item.order_tag   = i_order_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: src/csc_queue.sv
// ============================================================================
// csc_queue
// Short first-in first-out queue of classified items.
// ============================================================================
module csc_queue import csc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: src/csc_back.sv
// ============================================================================
// csc_back
// Carries out items against the socket state and registers the result.
// ============================================================================
module csc_back import csc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_valid,
    input  t_item   i_item,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_result
);

    t_sock       r_sock [SOCKETS];
    logic        r_out_valid;
    t_result     r_out;

    t_sock       cur;
    t_sock       nxt;
    t_result     res;
    t_outcome    outcome;
    logic        fin;
    t_end        reason;
    logic [31:0] ftag;
    logic [31:0] elapsed;
    logic [31:0] since_pulse;
    logic [31:0] since_check;
    logic        time_up;
    logic        delay_done;
    logic        pulse_due;
    logic        pulses_moved;
    logic        stalled;

    assign o_pop       = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        cur          = r_sock[i_item.idx];
        nxt          = cur;
        outcome      = OUT_NONE;
        fin          = 1'b0;
        reason       = END_TIME_UP;
        ftag         = '0;
        elapsed      = i_item.now_ms - cur.start_time;
        since_pulse  = i_item.now_ms - cur.last_pulse_time;
        since_check  = i_item.now_ms - cur.last_check_time;
        time_up      = (elapsed >= cur.limit_ms);
        delay_done   = (elapsed > i_cfg.no_current_delay_ms);
        pulse_due    = (since_pulse >= i_cfg.pulse_check_min_ms);
        pulses_moved = (i_item.pulse_count > cur.last_pulse_count);
        stalled      = (since_pulse > i_cfg.no_current_window_ms);

        case (i_item.op)
            OP_START: begin
                if (!cur.charging) begin
                    nxt.charging         = 1'b1;
                    nxt.held_order_tag   = i_item.order_tag;
                    nxt.limit_ms         = i_item.limit_ms;
                    nxt.start_time       = i_item.now_ms;
                    nxt.last_pulse_count = i_item.pulse_count;
                    nxt.last_pulse_time  = i_item.now_ms;
                    nxt.last_check_time  = i_item.now_ms;
                    outcome              = OUT_STARTED;
                end else begin
                    outcome = OUT_START_IGN;
                end
            end
            OP_STOP: begin
                if (cur.charging) begin
                    fin     = 1'b1;
                    reason  = END_MANUAL;
                    outcome = OUT_STOPPED;
                end else begin
                    outcome = OUT_STOP_IGN;
                end
            end
            OP_CHECK: begin
                if (cur.charging && (since_check >= {16'd0, i_cfg.check_interval_ms})) begin
                    nxt.last_check_time = i_item.now_ms;
                    if (time_up) begin
                        fin    = 1'b1;
                        reason = END_TIME_UP;
                    end else if (i_item.fuse_blown) begin
                        fin    = 1'b1;
                        reason = END_FUSE;
                    end else if (delay_done && pulse_due) begin
                        if (pulses_moved) begin
                            nxt.last_pulse_count = i_item.pulse_count;
                            nxt.last_pulse_time  = i_item.now_ms;
                        end else if (stalled) begin
                            fin    = 1'b1;
                            reason = END_NO_CURRENT;
                        end
                    end
                    if (fin) begin
                        outcome = OUT_ENDED;
                    end
                end
            end
            default: begin
            end
        endcase

        // Ending a charge clears the order but keeps the last check time.
        if (fin) begin
            ftag                 = cur.held_order_tag;
            nxt.charging         = 1'b0;
            nxt.held_order_tag   = '0;
            nxt.limit_ms         = '0;
            nxt.start_time       = '0;
            nxt.last_pulse_count = '0;
            nxt.last_pulse_time  = '0;
            nxt.last_end_reason  = reason;
        end

        res        = '0;
        res.socket = i_item.socket;
        if (i_item.bad) begin
            res.outcome    = OUT_BAD;
            res.stop_cause = END_TIME_UP;
        end else begin
            res.outcome        = outcome;
            res.relay_closed   = nxt.charging;
            res.finished_event = fin;
            res.stop_cause     = fin ? reason : cur.last_end_reason;
            res.finished_tag   = ftag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SOCKETS; i++) begin
                r_sock[i] <= '0;
            end
        end else if (o_pop && !i_item.bad) begin
            r_sock[i_item.idx] <= nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= res;
        end
    end

endmodule

FILE: src/charge_socket_controller.sv
// ============================================================================
// charge_socket_controller
// Per-socket charging controller: start and stop orders and periodic checks.
// ============================================================================
//
//  Channel   Direction  Handshake                   Payload
//  -------   ---------  --------------------------  ------------------------------
//  in        input      i_in_valid / o_in_stall     opcode, socket, now_ms, pulses,
//                                                   fuse, minutes, order tag
//  out       output     o_out_valid / i_out_stall   socket, outcome, relay, event,
//                                                   stop cause, finished tag
//  cfg       input      i_cfg_we (no stall)         i_cfg_index, i_cfg_data
//
// One beat is accepted per clock when nothing stalls; a result is offered once
// its input beat has passed the front register, the queue and the output register.
// The back part reads and writes the state of one socket in the same cycle,
// which sets the rate of one item per clock while the output does not stall.
// Reset is synchronous and active low; it clears all socket state and loads
// the register defaults. A stall on the output fills the two-entry queue and
// then the front register before the input channel is stalled.
//
module charge_socket_controller import csc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [1:0]  i_socket,
    input  logic [31:0] i_now_ms,
    input  logic [31:0] i_pulse_count,
    input  logic        i_fuse_blown,
    input  logic [15:0] i_minutes,
    input  logic [31:0] i_order_tag,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_socket,
    output logic [2:0]  o_outcome,
    output logic        o_relay_closed,
    output logic        o_finished_event,
    output logic [1:0]  o_stop_cause,
    output logic [31:0] o_finished_tag
);

    t_cfg    r_cfg;
    logic    queue_full;
    logic    push;
    t_item   front_item;
    logic    pop;
    logic    q_valid;
    t_item   q_item;
    t_result result;

    // Configuration registers. Writes must arrive only while the block is
    // idle (not enforced by the block); front and back read them without hand-over.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_interval_ms    <= RST_CHECK_INTERVAL;
            r_cfg.no_current_delay_ms  <= RST_NC_DELAY;
            r_cfg.no_current_window_ms <= RST_NC_WINDOW;
            r_cfg.pulse_check_min_ms   <= RST_PULSE_MIN;
            r_cfg.default_minutes      <= RST_DEFAULT_MIN;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CHECK_INTERVAL: r_cfg.check_interval_ms    <= i_cfg_data[15:0];
                CFG_NC_DELAY:       r_cfg.no_current_delay_ms  <= i_cfg_data;
                CFG_NC_WINDOW:      r_cfg.no_current_window_ms <= i_cfg_data;
                CFG_PULSE_MIN:      r_cfg.pulse_check_min_ms   <= i_cfg_data;
                CFG_DEFAULT_MIN:    r_cfg.default_minutes      <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // The front part decodes the beat, rejects sockets that do not exist and
    // turns the planned minutes into a time limit in milliseconds.
    csc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_opcode          (i_opcode),
        .i_socket          (i_socket),
        .i_now_ms          (i_now_ms),
        .i_pulse_count     (i_pulse_count),
        .i_fuse_blown      (i_fuse_blown),
        .i_minutes         (i_minutes),
        .i_order_tag       (i_order_tag),
        .i_default_minutes (r_cfg.default_minutes),
        .i_queue_full      (queue_full),
        .o_push            (push),
        .o_item            (front_item)
    );

    // The queue lets the front keep accepting while the back waits on the
    // output channel.
    csc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // The back part holds the socket state, applies orders and safety checks
    // and keeps the result in an output register until it is taken.
    csc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_item      (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    assign o_result_socket  = result.socket;
    assign o_outcome        = result.outcome;
    assign o_relay_closed   = result.relay_closed;
    assign o_finished_event = result.finished_event;
    assign o_stop_cause     = result.stop_cause;
    assign o_finished_tag   = result.finished_tag;

endmodule
